@@ hdl/djs_pkg.sv @@
// shared types and constants for the deadline job scheduler
package djs_pkg;

  localparam int MAX_JOBS_DEF    = 64;
  localparam int PROFIT_BITS_DEF = 16;
  localparam int PROFIT_W        = 16;
  localparam int DEADLINE_W      = 7;
  localparam int JOB_NUM_W       = 7;

  typedef struct packed {
    logic [PROFIT_W-1:0]   profit;
    logic [DEADLINE_W-1:0] deadline;
    logic                  last_job;
  } job_t;

  typedef struct packed {
    logic [JOB_NUM_W-1:0] job_number;
    logic                 empty_schedule;
    logic                 last_result;
  } result_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_SCAN,
    ST_PICK,
    ST_SEARCH,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } djs_state_t;

  typedef struct packed {
    logic load;
    logic pass_init;
    logic pass_start;
    logic scan_step;
    logic pick;
    logic search_step;
    logic emit_rd;
    logic emit_ld;
    logic clear_count;
  } djs_cmd_t;

  typedef struct packed {
    logic all_passes;
    logic scan_end;
    logic search_done;
    logic out_last;
  } djs_status_t;

endpackage

@@ hdl/djs_ctrl.sv @@
// sequencing state machine: load, selection passes, slot search, result emit
module djs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  logic                job_last,
  input  logic                result_valid,
  input  logic                result_ready,
  input  djs_pkg::djs_status_t status,
  output logic                job_ready,
  output djs_pkg::djs_cmd_t   cmd
);
  import djs_pkg::*;

  djs_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:      if (job_valid && job_last) state_next = ST_PASS;
      ST_PASS:      state_next = status.all_passes ? ST_EMIT_RD : ST_SCAN;
      ST_SCAN:      if (status.scan_end) state_next = ST_PICK;
      ST_PICK:      state_next = ST_SEARCH;
      ST_SEARCH:    if (status.search_done) state_next = ST_PASS;
      ST_EMIT_RD:   state_next = ST_EMIT_LD;
      ST_EMIT_LD:   state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (result_valid && result_ready)
          state_next = status.out_last ? ST_LOAD : ST_EMIT_RD;
      end
      default:      state_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    job_ready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        job_ready     = 1'b1;
        cmd.load      = job_valid;
        cmd.pass_init = job_valid && job_last;
      end
      ST_PASS:      cmd.pass_start  = !status.all_passes;
      ST_SCAN:      cmd.scan_step   = 1'b1;
      ST_PICK:      cmd.pick        = 1'b1;
      ST_SEARCH:    cmd.search_step = 1'b1;
      ST_EMIT_RD:   cmd.emit_rd     = 1'b1;
      ST_EMIT_LD:   cmd.emit_ld     = 1'b1;
      ST_EMIT_WAIT: cmd.clear_count = result_valid && result_ready && status.out_last;
      default:      cmd = '0;
    endcase
  end

endmodule

@@ hdl/djs_dp.sv @@
// job stores, max-profit selection, slot search and result buffer
module djs_dp #(
  parameter int MAX_JOBS    = djs_pkg::MAX_JOBS_DEF,
  parameter int PROFIT_BITS = djs_pkg::PROFIT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  djs_pkg::job_t        job,
  input  djs_pkg::djs_cmd_t    cmd,
  input  logic                 result_ready,
  output djs_pkg::result_t     result,
  output logic                 result_valid,
  output djs_pkg::djs_status_t status
);
  import djs_pkg::*;

  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int SW = (PROFIT_BITS < PROFIT_W) ? PROFIT_BITS : PROFIT_W;

  logic [SW-1:0]       mem_profit [MAX_JOBS];
  logic [CW-1:0]       mem_dl     [MAX_JOBS];
  logic [IW-1:0]       res_mem    [MAX_JOBS];

  logic [CW-1:0]       job_count;
  logic [SW-1:0]       rd_profit;
  logic [CW-1:0]       rd_dl;
  logic [CW-1:0]       scan_idx;
  logic                cmp_vld;
  logic [IW-1:0]       cmp_idx;
  logic [MAX_JOBS-1:0] done;
  logic                best_found;
  logic [SW-1:0]       best_profit;
  logic [IW-1:0]       best_idx;
  logic [CW-1:0]       best_dl;
  logic [CW-1:0]       pass_cnt;
  logic [CW-1:0]       slot;
  logic [MAX_JOBS:0]   used;
  logic [CW-1:0]       res_cnt;
  logic [CW-1:0]       emit_idx;
  logic [IW-1:0]       res_rd;

  logic [CW-1:0]       dl_sat;
  logic                scan_go;
  logic                slot_free;

  // deadline saturation
  always_comb begin
    if (job.deadline > DEADLINE_W'(MAX_JOBS)) dl_sat = CW'(MAX_JOBS);
    else                                      dl_sat = CW'(job.deadline);
  end

  assign scan_go   = cmd.scan_step && (scan_idx != job_count);
  assign slot_free = (slot != '0) && !used[slot];

  assign status.all_passes  = (pass_cnt == job_count);
  assign status.scan_end    = (scan_idx == job_count) && !cmp_vld;
  assign status.search_done = (slot == '0) || !used[slot];
  assign status.out_last    = result.last_result;

  // job stores
  always_ff @(posedge clk) begin
    if (cmd.load && (job_count < CW'(MAX_JOBS))) begin
      mem_profit[job_count[IW-1:0]] <= job.profit[SW-1:0];
      mem_dl[job_count[IW-1:0]]     <= dl_sat;
    end
    if (scan_go) begin
      rd_profit <= mem_profit[scan_idx[IW-1:0]];
      rd_dl     <= mem_dl[scan_idx[IW-1:0]];
    end
  end

  // job count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_count)
      job_count <= '0;
    else if (cmd.load && (job_count < CW'(MAX_JOBS)))
      job_count <= job_count + CW'(1);
  end

  // selection scan: highest profit not yet taken, earliest on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else if (cmd.pass_start) begin
      scan_idx   <= '0;
      cmp_vld    <= 1'b0;
      best_found <= 1'b0;
    end else begin
      cmp_vld <= scan_go;
      if (scan_go) begin
        scan_idx <= scan_idx + CW'(1);
        cmp_idx  <= scan_idx[IW-1:0];
      end
      if (cmp_vld && !done[cmp_idx] && (!best_found || rd_profit > best_profit)) begin
        best_found  <= 1'b1;
        best_profit <= rd_profit;
        best_idx    <= cmp_idx;
        best_dl     <= rd_dl;
      end
    end
  end

  // pass bookkeeping and slot search
  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      pass_cnt <= '0;
      done     <= '0;
      used     <= '0;
      res_cnt  <= '0;
    end else if (cmd.pick) begin
      done[best_idx] <= 1'b1;
      slot           <= best_dl;
    end else if (cmd.search_step) begin
      if (status.search_done) pass_cnt <= pass_cnt + CW'(1);
      if (slot_free) begin
        used[slot] <= 1'b1;
        res_cnt    <= res_cnt + CW'(1);
      end else if (slot != '0) begin
        slot <= slot - CW'(1);
      end
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (cmd.search_step && slot_free) res_mem[res_cnt[IW-1:0]] <= best_idx;
    if (cmd.emit_rd) res_rd <= res_mem[emit_idx[IW-1:0]];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      result_valid <= 1'b1;
    end else if (result_valid && result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      emit_idx <= '0;
    end else if (cmd.emit_ld) begin
      if (res_cnt == '0) begin
        result.job_number     <= '0;
        result.empty_schedule <= 1'b1;
        result.last_result    <= 1'b1;
      end else begin
        result.job_number     <= JOB_NUM_W'(res_rd) + JOB_NUM_W'(1);
        result.empty_schedule <= 1'b0;
        result.last_result    <= (emit_idx + CW'(1) == res_cnt);
      end
    end else if (result_valid && result_ready) begin
      emit_idx <= emit_idx + CW'(1);
    end
  end

endmodule

@@ hdl/deadline_job_scheduler.sv @@
// job sequencing with deadlines: loads jobs, then emits the scheduled job numbers
// jobs load one per cycle; after the last job each of n selection passes
// scans the profit store, then walks down the slot map from the chosen job's deadline;
// each result is then read from the buffer, registered and held until taken;
// the single-port profit store read per cycle sets the scan length
// reset (rst, synchronous): empties the job set and returns to loading
module deadline_job_scheduler #(
  parameter int MAX_JOBS    = djs_pkg::MAX_JOBS_DEF,
  parameter int PROFIT_BITS = djs_pkg::PROFIT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  djs_pkg::job_t    job,
  output logic             result_valid,
  input  logic             result_ready,
  output djs_pkg::result_t result
);
  import djs_pkg::*;

  djs_cmd_t    cmd;
  djs_status_t status;

  // controller
  djs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_last     (job.last_job),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .job_ready    (job_ready),
    .cmd          (cmd)
  );

  // datapath
  djs_dp #(
    .MAX_JOBS    (MAX_JOBS),
    .PROFIT_BITS (PROFIT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .cmd          (cmd),
    .result_ready (result_ready),
    .result       (result),
    .result_valid (result_valid),
    .status       (status)
  );

endmodule

@@ hdl/djs_checker.sv @@
// port-level checks for the deadline job scheduler
module djs_checker (
  input logic             clk,
  input logic             rst,
  input logic             job_valid,
  input logic             job_ready,
  input djs_pkg::job_t    job,
  input logic             result_valid,
  input logic             result_ready,
  input djs_pkg::result_t result
);
  import djs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(job_ready && result_valid))
    else $error("job ready while result pending");

  // final result transfer reopens loading
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result.last_result |=> job_ready)
    else $error("not back to loading after final result");

  // empty schedule is a lone zero result
  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.empty_schedule |->
      result.job_number == '0 && result.last_result)
    else $error("malformed empty result");

  // last job transfer closes loading
  a_close: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready && job.last_job |=> !job_ready)
    else $error("still loading after last job");

endmodule

bind deadline_job_scheduler djs_checker u_djs_checker (
  .clk          (clk),
  .rst          (rst),
  .job_valid    (job_valid),
  .job_ready    (job_ready),
  .job          (job),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ tb/deadline_job_scheduler_test.sv @@
// testbench for the deadline job scheduler: greedy schedule prediction and result checks
`timescale 1ns / 1ps

module deadline_job_scheduler_test;
  import djs_pkg::*;

  localparam int JOBS_MAX = 64;

  logic    clk;
  logic    rst;
  logic    job_valid;
  logic    job_ready;
  job_t    job;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  // predictor state: the current job set
  logic [15:0] set_profit[JOBS_MAX];
  logic [6:0]  set_deadline[JOBS_MAX];
  int          set_size;
  result_t     expected_results[$];

  int fail_count;
  int jobs_sent;
  int sets_sent;
  int results_seen;
  int max_gap;
  int hold_cycles;

  deadline_job_scheduler uut (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job(job),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("FAIL");
    $finish;
  end

  // random gap length: mostly short, sometimes long
  function automatic int pick_gap(int limit);
    int r;
    r = $urandom_range(0, 99);
    if (limit == 0 || r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, limit);
  endfunction

  // compute the greedy schedule for the held set and queue it
  task automatic schedule_set();
    int order[JOBS_MAX];
    logic [6:0] link[JOBS_MAX+1];
    int i, j, k, d, root, cur, nxt, found;
    result_t r;
    found = 0;
    // stable sort by profit, highest first
    for (i = 0; i < set_size; i++) begin
      j = i;
      while (j > 0 && set_profit[order[j-1]] < set_profit[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i <= JOBS_MAX; i++) link[i] = 7'(i);
    for (i = 0; i < set_size; i++) begin
      k = order[i];
      d = set_deadline[k];
      root = d;
      while (link[root] != root) root = link[root];
      cur = d;
      while (cur != root) begin
        nxt = link[cur];
        link[cur] = 7'(root);
        cur = nxt;
      end
      if (root > 0) begin
        link[root] = 7'(root - 1);
        r.job_number = 7'(k + 1);
        r.empty_schedule = 1'b0;
        r.last_result = 1'b0;
        expected_results = {expected_results, r};
        found++;
      end
    end
    if (found == 0) begin
      r.job_number = '0;
      r.empty_schedule = 1'b1;
      r.last_result = 1'b1;
      expected_results = {expected_results, r};
    end else begin
      expected_results[$].last_result = 1'b1;
    end
    set_size = 0;
    sets_sent++;
  endtask

  // one job transfer, with prediction on acceptance
  task automatic send_job(input logic [15:0] p, input logic [6:0] dl, input logic last);
    int g;
    g = pick_gap(max_gap);
    if (g > 0) begin
      job_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    job_valid <= 1'b1;
    job <= '{profit: p, deadline: dl, last_job: last};
    do @(posedge clk); while (!job_ready);
    jobs_sent++;
    if (set_size < JOBS_MAX) begin
      set_profit[set_size] = p;
      set_deadline[set_size] = (dl > JOBS_MAX) ? 7'(JOBS_MAX) : dl;
      set_size++;
    end
    if (last) schedule_set();
  endtask

  task automatic wait_drained();
    job_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold when asked
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        result_ready <= 1'b0;
        hold_cycles--;
      end else if (max_gap > 0 && $urandom_range(0, 9) < 3) begin
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: job_number %0d", result.job_number);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.job_number !== want.job_number) begin
            $error("job_number expected %0d actual %0d", want.job_number, result.job_number);
            fail_count++;
          end
          if (result.empty_schedule !== want.empty_schedule) begin
            $error("empty_schedule expected %0b actual %0b",
                   want.empty_schedule, result.empty_schedule);
            fail_count++;
          end
          if (result.last_result !== want.last_result) begin
            $error("last_result expected %0b actual %0b", want.last_result, result.last_result);
            fail_count++;
          end
        end
      end
    end
  end

  // directed corner sets
  task automatic test_directed();
    int i;
    // single job at deadline zero: empty
    send_job(16'd5, 7'd0, 1'b1);
    // extremes of profit and deadline, saturation, ties
    send_job(16'hFFFF, 7'd127, 1'b0);
    send_job(16'h0000, 7'd64, 1'b0);
    send_job(16'hFFFF, 7'd1, 1'b0);
    send_job(16'h8000, 7'd65, 1'b0);
    send_job(16'h7FFF, 7'd1, 1'b0);
    send_job(16'h5555, 7'h55, 1'b0);
    send_job(16'hAAAA, 7'h2A, 1'b1);
    // contention on one slot
    for (i = 0; i < 5; i++) send_job(16'(i * 3), 7'd1, i == 4);
    // all deadlines zero
    send_job(16'd100, 7'd0, 1'b0);
    send_job(16'd200, 7'd0, 1'b1);
    wait_drained();
  endtask

  // store full: 66 jobs, the extra ones dropped
  task automatic test_overflow();
    int i;
    for (i = 0; i < 66; i++)
      send_job(16'($urandom), 7'($urandom_range(0, 127)), i == 65);
    wait_drained();
  endtask

  // receiver holds off while jobs keep arriving
  task automatic test_backpressure();
    int i;
    hold_cycles = 4000;
    for (i = 0; i < 4; i++) send_job(16'(i), 7'(i + 1), 1'b0);
    send_job(16'd9, 7'd5, 1'b1);
    for (i = 0; i < 6; i++) send_job(16'($urandom), 7'($urandom_range(1, 8)), i == 5);
    wait_drained();
  endtask

  // random sets, mostly small
  task automatic test_random(int count);
    int sent, len, i;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      if (len > count - sent) len = count - sent;
      for (i = 0; i < len; i++) begin
        send_job($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3)) : 16'($urandom),
                 $urandom_range(0, 4) == 0 ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, len + 1)),
                 i == len - 1);
      end
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    fail_count = 0;
    jobs_sent = 0;
    sets_sent = 0;
    results_seen = 0;
    set_size = 0;
    max_gap = 0;
    hold_cycles = 0;
    job_valid = 1'b0;
    job = '0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    max_gap = 12;
    test_overflow();
    test_backpressure();
    test_random(65);
    max_gap = 0;
    test_random(35);
    max_gap = 12;
    test_random(40);
    repeat (200) @(posedge clk);
    $display("covered %0d jobs in %0d sets, %0d results checked",
             jobs_sent, sets_sent, results_seen);
    $display("sets included empty, saturated, tied, overflowing and stalled cases");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
